// ===== rtl/sft_pkg.sv =====
// Shared types and constants for the spherical fault terrain step block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package sft_pkg;

  // Vertex store geometry
  localparam int MAX_VERTICES = 4096;
  localparam int VTX_AW       = $clog2(MAX_VERTICES);

  // Field widths
  localparam int CNT_W    = 13;
  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 18;
  localparam int DIR_W    = 3 * COORD_W;

  // Datapath widths: dot product, split point of the radius multiply, full product
  localparam int DOT_W  = 2 * COORD_W + 2;
  localparam int SPLIT  = 17;
  localparam int PROD_W = DOT_W + RADIUS_W + 1;

  // Radius update step and saturation limit (Q2.16)
  localparam logic [RADIUS_W-1:0] STEP_LSB   = RADIUS_W'(33);
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_VERTICES);

  // Configuration register index
  localparam int REG_VERTEX_COUNT = 0;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FAULT = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP_SQ,
    ST_PREP_SUM,
    ST_WALK,
    ST_DRAIN,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

  // Read request into the vertex store; walk marks entries bound for the fault pipe
  typedef struct packed {
    logic              rd_en;
    logic              walk;
    logic [VTX_AW-1:0] addr;
  } sft_issue_t;

  // Strobes raised when a word is taken
  typedef struct packed {
    logic load_we;
    logic point_ld;
  } sft_cmd_t;

  // Radius write-back from the fault pipe
  typedef struct packed {
    logic                we;
    logic [VTX_AW-1:0]   addr;
    logic [RADIUS_W-1:0] radius;
  } sft_wb_t;

  // Fault pipe status seen by the controller
  typedef struct packed {
    logic                busy;
    logic [RADIUS_W-1:0] highest;
  } sft_status_t;

endpackage

// ===== rtl/sft_vertex_store.sv =====
// Vertex store: direction memory and radius memory, registered reads.
// Depends on sft_pkg.

module sft_vertex_store (
  input  logic                             clk,
  input  sft_pkg::sft_issue_t              issue,
  input  logic                             load_we,
  input  logic [sft_pkg::VTX_AW-1:0]       load_addr,
  input  logic [sft_pkg::DIR_W-1:0]        load_dir,
  input  logic [sft_pkg::RADIUS_W-1:0]     load_radius,
  input  sft_pkg::sft_wb_t                 wb,
  output logic [sft_pkg::DIR_W-1:0]        dir_q,
  output logic [sft_pkg::RADIUS_W-1:0]     radius_q
);

  logic [sft_pkg::DIR_W-1:0]    dir_mem    [sft_pkg::MAX_VERTICES];
  logic [sft_pkg::RADIUS_W-1:0] radius_mem [sft_pkg::MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (load_we) begin
      dir_mem[load_addr] <= load_dir;
    end
    if (issue.rd_en) begin
      dir_q <= dir_mem[issue.addr];
    end
  end

  // Loads and write-backs never coincide: loads are taken only with the pipe empty
  always_ff @(posedge clk) begin
    if (load_we) begin
      radius_mem[load_addr] <= load_radius;
    end else if (wb.we) begin
      radius_mem[wb.addr] <= wb.radius;
    end
    if (issue.rd_en) begin
      radius_q <= radius_mem[issue.addr];
    end
  end

endmodule

// ===== rtl/sft_fault_pipe.sv =====
// Fault pipeline: plane test and saturating radius update for each walked vertex,
// plus the running highest radius. Depends on sft_pkg.

module sft_fault_pipe (
  input  logic                             clk,
  input  logic                             rst,
  input  sft_pkg::sft_issue_t              issue,
  input  logic                             point_ld,
  input  logic signed [sft_pkg::COORD_W-1:0] px_in,
  input  logic signed [sft_pkg::COORD_W-1:0] py_in,
  input  logic signed [sft_pkg::COORD_W-1:0] pz_in,
  input  logic                             raise_in,
  input  logic [sft_pkg::DIR_W-1:0]        dir_q,
  input  logic [sft_pkg::RADIUS_W-1:0]     radius_q,
  output sft_pkg::sft_wb_t                 wb,
  output sft_pkg::sft_status_t             status
);

  localparam int CW = sft_pkg::COORD_W;
  localparam int RW = sft_pkg::RADIUS_W;
  localparam int AW = sft_pkg::VTX_AW;
  localparam int DW = sft_pkg::DOT_W;
  localparam int PW = sft_pkg::PROD_W;
  localparam int SP = sft_pkg::SPLIT;

  // Fault point and the plane offset |p|^2 << 16
  logic signed [CW-1:0]   px, py, pz;
  logic                   raise;
  logic signed [2*CW-1:0] sq_x, sq_y, sq_z;
  logic signed [PW-1:0]   rhs;

  always_ff @(posedge clk) begin
    if (point_ld) begin
      px    <= px_in;
      py    <= py_in;
      pz    <= pz_in;
      raise <= raise_in;
    end
    sq_x <= px * px;
    sq_y <= py * py;
    sq_z <= pz * pz;
    rhs  <= $signed({(PW - 2*CW - 16)'(0),
                     sq_x[2*CW-1:0] + sq_y[2*CW-1:0] + sq_z[2*CW-1:0], 16'b0});
  end

  // Stage valids
  logic v0, va, vb, vc, vd, ve;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      v0 <= issue.rd_en & issue.walk;
      va <= v0;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
    end
  end

  // Payload along the pipe
  logic [AW-1:0]          addr0, addr_a, addr_b, addr_c, addr_d, addr_e;
  logic [RW-1:0]          r_a, r_b, r_c, r_d;
  logic signed [2*CW-1:0] mx, my, mz;
  logic signed [DW-1:0]   dot;
  logic signed [RW+SP+1:0] part_hi;
  logic [RW+SP-1:0]       part_lo;
  logic signed [PW-1:0]   prod;
  logic [RW-1:0]          r_e;

  logic signed [CW-1:0] dx, dy, dz;
  assign dx = $signed(dir_q[CW-1:0]);
  assign dy = $signed(dir_q[2*CW-1:CW]);
  assign dz = $signed(dir_q[3*CW-1:2*CW]);

  logic          up;
  logic [RW-1:0] r_new;

  always_comb begin
    up = (prod > rhs) == raise;
    if (up) begin
      r_new = (r_d > sft_pkg::RADIUS_MAX - sft_pkg::STEP_LSB) ? sft_pkg::RADIUS_MAX
                                                             : r_d + sft_pkg::STEP_LSB;
    end else begin
      r_new = (r_d < sft_pkg::STEP_LSB) ? '0 : r_d - sft_pkg::STEP_LSB;
    end
  end

  always_ff @(posedge clk) begin
    addr0 <= issue.addr;
    // direction times point
    mx     <= dx * px;
    my     <= dy * py;
    mz     <= dz * pz;
    r_a    <= radius_q;
    addr_a <= addr0;
    // dot product
    dot    <= DW'(mx) + DW'(my) + DW'(mz);
    r_b    <= r_a;
    addr_b <= addr_a;
    // radius times dot, split into a signed upper and an unsigned lower partial product
    part_hi <= $signed({1'b0, r_b}) * $signed(dot[DW-1:SP]);
    part_lo <= r_b * dot[SP-1:0];
    r_c     <= r_b;
    addr_c  <= addr_b;
    // recombine
    prod   <= (PW'(part_hi) <<< SP) + $signed({(PW - RW - SP)'(0), part_lo});
    r_d    <= r_c;
    addr_d <= addr_c;
    // plane test and saturating step
    r_e    <= r_new;
    addr_e <= addr_d;
  end

  logic [RW-1:0] highest;

  always_ff @(posedge clk) begin
    if (rst) begin
      highest <= '0;
    end else if (ve && r_e > highest) begin
      highest <= r_e;
    end
  end

  assign wb.we          = ve;
  assign wb.addr        = addr_e;
  assign wb.radius      = r_e;
  assign status.busy    = v0 | va | vb | vc | vd | ve;
  assign status.highest = highest;

endmodule

// ===== rtl/sft_ctrl.sv =====
// Sequencer: takes words, walks the vertex store for fault items, and holds the
// result register. Depends on sft_pkg.

module sft_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [1:0]                       req_type,
  input  logic [11:0]                      vertex_index,
  input  logic [sft_pkg::CNT_W-1:0]        vertex_count,
  input  logic [sft_pkg::RADIUS_W-1:0]     radius_q,
  input  sft_pkg::sft_status_t             status,
  output sft_pkg::sft_issue_t              issue,
  output sft_pkg::sft_cmd_t                cmd,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [1:0]                       done_kind,
  output logic [sft_pkg::RADIUS_W-1:0]     read_radius,
  output logic [sft_pkg::RADIUS_W-1:0]     highest_radius
);

  localparam int RW = sft_pkg::RADIUS_W;
  localparam int NW = sft_pkg::CNT_W;
  localparam int AW = sft_pkg::VTX_AW;

  sft_pkg::state_t state, state_next;

  logic          accept;
  logic          idx_ok;
  logic          out_load;
  logic [NW-1:0] walk_idx;
  logic [NW-1:0] walk_last;
  logic [NW-1:0] count_lim;
  logic [1:0]    kind;
  logic          rd_ok;
  logic [RW-1:0] rd_val;

  assign accept   = s_tvalid & s_tready;
  assign idx_ok   = 32'(vertex_index) < sft_pkg::MAX_VERTICES;
  assign out_load = !m_tvalid || m_tready;
  assign count_lim = (32'(vertex_count) > sft_pkg::MAX_VERTICES) ?
                     NW'(sft_pkg::MAX_VERTICES) : vertex_count;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sft_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (req_type)
            sft_pkg::REQ_FAULT: state_next = sft_pkg::ST_PREP_SQ;
            sft_pkg::REQ_READ:  state_next = sft_pkg::ST_RD_WAIT;
            default:            state_next = sft_pkg::ST_FINISH;
          endcase
        end
      end
      sft_pkg::ST_PREP_SQ:  state_next = sft_pkg::ST_PREP_SUM;
      sft_pkg::ST_PREP_SUM: begin
        state_next = (walk_last == '1) ? sft_pkg::ST_FINISH : sft_pkg::ST_WALK;
      end
      sft_pkg::ST_WALK: begin
        if (walk_idx == walk_last) state_next = sft_pkg::ST_DRAIN;
      end
      sft_pkg::ST_DRAIN: begin
        if (!status.busy) state_next = sft_pkg::ST_FINISH;
      end
      sft_pkg::ST_RD_WAIT: state_next = sft_pkg::ST_FINISH;
      sft_pkg::ST_FINISH: begin
        if (out_load) state_next = sft_pkg::ST_IDLE;
      end
      default: state_next = sft_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready     = 1'b0;
    issue.rd_en  = 1'b0;
    issue.walk   = 1'b0;
    issue.addr   = walk_idx[AW-1:0];
    cmd.load_we  = 1'b0;
    cmd.point_ld = 1'b0;
    case (state)
      sft_pkg::ST_IDLE: begin
        s_tready     = 1'b1;
        issue.addr   = vertex_index[AW-1:0];
        issue.rd_en  = s_tvalid && req_type == sft_pkg::REQ_READ;
        cmd.load_we  = s_tvalid && req_type == sft_pkg::REQ_LOAD && idx_ok;
        cmd.point_ld = s_tvalid && req_type == sft_pkg::REQ_FAULT;
      end
      sft_pkg::ST_WALK: begin
        issue.rd_en = 1'b1;
        issue.walk  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sft_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sft_pkg::ST_FINISH && out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind      <= req_type;
      rd_ok     <= idx_ok;
      rd_val    <= '0;
      walk_idx  <= '0;
      walk_last <= count_lim - NW'(1);
    end
    if (state == sft_pkg::ST_WALK) begin
      walk_idx <= walk_idx + NW'(1);
    end
    if (state == sft_pkg::ST_RD_WAIT) begin
      rd_val <= rd_ok ? radius_q : '0;
    end
    if (state == sft_pkg::ST_FINISH && out_load) begin
      done_kind      <= kind;
      read_radius    <= rd_val;
      highest_radius <= status.highest;
    end
  end

endmodule

// ===== rtl/spherical_fault_terrain_step.sv =====
// Top level of the spherical fault terrain step: stream ports, APB register,
// and the vertex store, fault pipe and sequencer. Depends on sft_pkg and its modules.

// Keeps up to 4096 sphere vertices (a Q1.14 unit direction and a Q2.16 radius each)
// in two synchronous memories with one read and one write port each. A load word writes
// one vertex, a read word returns one radius, and a fault word carries a point p and a
// sign: every vertex from index 0 up to vertex_count-1, capped at 4095, is raised or
// lowered by 33 LSB depending on whether r*(n.p) exceeds |p|^2, saturating at 0 and
// full scale, and the highest radius ever reached is tracked. Exactly one result word
// comes back for each word taken, in order. Words are handled one at a time: a fault
// word occupies the block while its vertices are walked, as the radius memory serves
// one read per cycle, and while the plane test runs through a six-stage pipe that
// drains before the result is formed. A read word also waits for its memory read; a
// load or unrecognised word does not. A new word is taken while the previous result
// still sits in the output register. Memories are not cleared after reset: read or walk
// only vertices that have been loaded. Write vertex_count only while the block is idle.

module spherical_fault_terrain_step (
  input  logic        clk,
  input  logic        rst,
  // Input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // vertex_index[11:0], coord_x[27:12], coord_y[43:28],
                                 // coord_z[59:44], radius_in[77:60], raise_side[78]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  // Result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_radius[17:0], highest_radius[35:18]
  output logic [1:0]  m_tuser,   // done_kind[1:0]
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = sft_pkg::COORD_W;
  localparam int RW = sft_pkg::RADIUS_W;
  localparam int NW = sft_pkg::CNT_W;
  localparam int AW = sft_pkg::VTX_AW;

  // Unpack the input word
  logic [11:0]          vertex_index;
  logic signed [CW-1:0] coord_x, coord_y, coord_z;
  logic [RW-1:0]        radius_in;
  logic                 raise_side;

  assign vertex_index = s_tdata[11:0];
  assign coord_x      = $signed(s_tdata[27:12]);
  assign coord_y      = $signed(s_tdata[43:28]);
  assign coord_z      = $signed(s_tdata[59:44]);
  assign radius_in    = s_tdata[77:60];
  assign raise_side   = s_tdata[78];

  // APB register: vertex_count at byte address 0
  logic [NW-1:0] vertex_count;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = 32'(paddr[2]) == sft_pkg::REG_VERTEX_COUNT;
  assign prdata  = reg_sel ? 32'(vertex_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= sft_pkg::COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      vertex_count <= pwdata[NW-1:0];
    end
  end

  sft_pkg::sft_issue_t  issue;
  sft_pkg::sft_cmd_t    cmd;
  sft_pkg::sft_wb_t     wb;
  sft_pkg::sft_status_t status;

  logic [sft_pkg::DIR_W-1:0] dir_q;
  logic [RW-1:0]             radius_q;
  logic [1:0]                done_kind;
  logic [RW-1:0]             read_radius;
  logic [RW-1:0]             highest_radius;

  sft_vertex_store u_store (
    .clk         (clk),
    .issue       (issue),
    .load_we     (cmd.load_we),
    .load_addr   (vertex_index[AW-1:0]),
    .load_dir    ({coord_z, coord_y, coord_x}),
    .load_radius (radius_in),
    .wb          (wb),
    .dir_q       (dir_q),
    .radius_q    (radius_q)
  );

  sft_fault_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .point_ld (cmd.point_ld),
    .px_in    (coord_x),
    .py_in    (coord_y),
    .pz_in    (coord_z),
    .raise_in (raise_side),
    .dir_q    (dir_q),
    .radius_q (radius_q),
    .wb       (wb),
    .status   (status)
  );

  sft_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .req_type       (s_tuser),
    .vertex_index   (vertex_index),
    .vertex_count   (vertex_count),
    .radius_q       (radius_q),
    .status         (status),
    .issue          (issue),
    .cmd            (cmd),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .done_kind      (done_kind),
    .read_radius    (read_radius),
    .highest_radius (highest_radius)
  );

  // Pack the result word
  assign m_tuser = done_kind;
  assign m_tdata = {4'b0, highest_radius, read_radius};

endmodule

// ===== verif/sft_tb_pkg.sv =====
// Request and result word types plus the terrain tracker class that predicts and checks
// each result word. Depends on sft_pkg for the request codes, widths and radius limits.
`timescale 1ns / 100ps

package sft_tb_pkg;
  import sft_pkg::*;

  typedef struct packed {
    logic [1:0]                kind;
    logic [VTX_AW-1:0]         index;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RADIUS_W-1:0]       radius;
    logic                      raise;
  } terrain_req_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [RADIUS_W-1:0] read_radius;
    logic [RADIUS_W-1:0] highest;
  } terrain_done_t;

  class terrain_tracker;
    logic signed [COORD_W-1:0] dir_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] dir_y [MAX_VERTICES];
    logic signed [COORD_W-1:0] dir_z [MAX_VERTICES];
    logic [RADIUS_W-1:0]       radius_mem [MAX_VERTICES];
    logic [RADIUS_W-1:0]       highest;
    logic [CNT_W-1:0]          walk_count;
    terrain_done_t             pending_done [$];
    int                        fail_count;

    function new();
      highest    = '0;
      walk_count = COUNT_RESET;
      fail_count = 0;
    endfunction

    function void set_walk_count(logic [CNT_W-1:0] v);
      walk_count = v;
    endfunction

    function int outstanding();
      return pending_done.size();
    endfunction

    // Update the vertex copy for one accepted word and queue the result it must give
    function void take_request(terrain_req_t rq);
      terrain_done_t res;
      longint        pp;
      longint        rhs;
      longint        dot;
      int unsigned   r;
      int unsigned   span;
      bit            beyond;
      res.kind        = rq.kind;
      res.read_radius = '0;
      case (rq.kind)
        REQ_LOAD: begin
          dir_x[rq.index]      = rq.x;
          dir_y[rq.index]      = rq.y;
          dir_z[rq.index]      = rq.z;
          radius_mem[rq.index] = rq.radius;
        end
        REQ_FAULT: begin
          pp   = longint'(rq.x) * rq.x + longint'(rq.y) * rq.y + longint'(rq.z) * rq.z;
          rhs  = pp <<< 16;
          span = (walk_count > MAX_VERTICES) ? MAX_VERTICES : walk_count;
          for (int j = 0; j < span; j++) begin
            dot = longint'(dir_x[j]) * rq.x + longint'(dir_y[j]) * rq.y
                + longint'(dir_z[j]) * rq.z;
            r = radius_mem[j];
            beyond = (longint'(r) * dot) > rhs;
            if (beyond == rq.raise) begin
              r = (r > int'(RADIUS_MAX) - int'(STEP_LSB)) ? int'(RADIUS_MAX) : r + STEP_LSB;
            end else begin
              r = (r < STEP_LSB) ? 0 : r - STEP_LSB;
            end
            radius_mem[j] = r[RADIUS_W-1:0];
            if (r > highest) highest = r[RADIUS_W-1:0];
          end
        end
        REQ_READ: res.read_radius = radius_mem[rq.index];
        default: ;
      endcase
      res.highest = highest;
      pending_done = {pending_done, res};
    endfunction

    function void flag_field(string what, longint unsigned want, longint unsigned got);
      if (want != got) begin
        fail_count++;
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, want, got);
      end
    endfunction

    // Compare one result word with the oldest expectation
    function void check_done(terrain_done_t got);
      terrain_done_t want;
      if (pending_done.size() == 0) begin
        fail_count++;
        $display("%0t: result word with none expected, actual 0x%0h", $time, got);
        return;
      end
      want = pending_done.pop_front();
      flag_field("done_kind", want.kind, got.kind);
      flag_field("read_radius", want.read_radius, got.read_radius);
      flag_field("highest_radius", want.highest, got.highest);
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
// Top level of the spherical fault terrain step testbench: clock, reset, stream and APB
// drivers, result monitor. Depends on sft_pkg, sft_tb_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import sft_pkg::*;
  import sft_tb_pkg::*;

  // Request code the block does not know; it must echo it and change nothing
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;   // vertex_index[11:0], coord_x[27:12], coord_y[43:28],
                          // coord_z[59:44], radius_in[77:60], raise_side[78]
  logic [1:0]  s_tuser;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // read_radius[17:0], highest_radius[35:18]
  logic [1:0]  m_tuser;   // done_kind[1:0]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  terrain_tracker tracker;
  bit             idle_on;
  int             stall_left;
  bit             loaded [MAX_VERTICES];
  int             loaded_idx [$];

  spherical_fault_terrain_step i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Result side: stall at random while idling is on, else stay ready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Take every result word that crosses the handshake and check it against the queue
  always @(posedge clk) begin
    terrain_done_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen.kind        = m_tuser;
      seen.read_radius = m_tdata[17:0];
      seen.highest     = m_tdata[35:18];
      tracker.check_done(seen);
    end
  end

  function automatic terrain_req_t make_req(logic [1:0] kind, int idx, int x, int y, int z,
                                            int r, bit raise);
    terrain_req_t rq;
    rq.kind   = kind;
    rq.index  = VTX_AW'(idx);
    rq.x      = COORD_W'(x);
    rq.y      = COORD_W'(y);
    rq.z      = COORD_W'(z);
    rq.radius = RADIUS_W'(r);
    rq.raise  = raise;
    return rq;
  endfunction

  function automatic int coord_in(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Offer one word, possibly after a short gap, and hold it until the block takes it.
  // tvalid stays high between back-to-back words, so it is never lowered and raised
  // in the same step.
  task automatic send_request(input terrain_req_t rq);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rq.kind;
    s_tdata  <= {1'b0, rq.raise, rq.radius, rq.z, rq.y, rq.x, rq.index};
    do @(posedge clk); while (!s_tready);
    tracker.take_request(rq);
    if (rq.kind == REQ_LOAD && !loaded[rq.index]) begin
      loaded[rq.index] = 1'b1;
      loaded_idx = {loaded_idx, int'(rq.index)};
    end
  endtask

  // Drop valid, wait for every expected word, then let the pipe run dry
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value once pready is seen
  task automatic write_count(input logic [CNT_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_VERTEX_COUNT);
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_walk_count(v);
  endtask

  // Mixed words with random content. Loads mostly land in the low indices so that they
  // feed the walked range; reads only address loaded vertices; faults only walk the
  // first sixteen, which the directed part has loaded.
  task automatic run_random_phase(input int n);
    terrain_req_t rq;
    int           pick;
    int           sel;
    int           lim;
    repeat (n) begin
      pick      = $urandom_range(0, 99);
      sel       = $urandom_range(0, 9);
      rq.index  = VTX_AW'($urandom);
      rq.x      = COORD_W'(coord_in(16384));
      rq.y      = COORD_W'(coord_in(16384));
      rq.z      = COORD_W'(coord_in(16384));
      rq.radius = RADIUS_W'($urandom);
      rq.raise  = 1'($urandom);
      if (pick < 35) begin
        rq.kind = REQ_LOAD;
        if ($urandom_range(0, 1) == 0) rq.index = VTX_AW'($urandom_range(0, 31));
        // skew radii towards both saturation limits
        if (sel < 2) rq.radius = RADIUS_W'($urandom_range(0, 100));
        else if (sel < 4) rq.radius = RADIUS_W'($urandom_range(262043, 262143));
      end else if (pick < 70) begin
        rq.kind = REQ_FAULT;
        // mostly points well inside the unit ball, sometimes near the centre
        if (sel < 7) begin
          lim  = (sel < 2) ? 1024 : 9000;
          rq.x = COORD_W'(coord_in(lim));
          rq.y = COORD_W'(coord_in(lim));
          rq.z = COORD_W'(coord_in(lim));
        end
      end else if (pick < 95) begin
        rq.kind  = REQ_READ;
        rq.index = VTX_AW'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
      end else begin
        rq.kind = REQ_UNKNOWN;
      end
      send_request(rq);
    end
  endtask

  initial begin
    tracker  = new();
    idle_on  = 1'b1;
    stall_left = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: walk sixteen vertices with extreme directions and radii
    write_count(CNT_W'(16));
    send_request(make_req(REQ_LOAD, 0, 16384, 0, 0, 65536, 1'b0));
    send_request(make_req(REQ_LOAD, 1, -16384, -16384, -16384, 262143, 1'b0));
    send_request(make_req(REQ_LOAD, 2, 0, 16384, 0, 0, 1'b1));
    send_request(make_req(REQ_LOAD, 3, 0, 0, -16384, 262143 - 20, 1'b0));
    send_request(make_req(REQ_LOAD, 4, 16384, 16384, 16384, 20, 1'b1));
    for (int i = 5; i < 16; i++) begin
      send_request(make_req(REQ_LOAD, i, coord_in(16384), coord_in(16384),
                            coord_in(16384), $urandom_range(0, 262143), 1'b0));
    end
    send_request(make_req(REQ_LOAD, 4095, -16384, 16384, -1, 'h2AAAA, 1'b1));
    send_request(make_req(REQ_READ, 4095, 0, 0, 0, 0, 1'b0));
    send_request(make_req(REQ_READ, 1, 0, 0, 0, 0, 1'b0));
    send_request(make_req(REQ_UNKNOWN, 7, 123, -456, 789, 1000, 1'b1));
    // point at the centre: no vertex lies beyond, all move the non-beyond way
    send_request(make_req(REQ_FAULT, 0, 0, 0, 0, 0, 1'b1));
    send_request(make_req(REQ_FAULT, 0, 16384, 16384, 16384, 0, 1'b0));
    send_request(make_req(REQ_FAULT, 0, -16384, -16384, -16384, 0, 1'b1));
    send_request(make_req(REQ_FAULT, 0, 8192, 0, 0, 0, 1'b1));
    send_request(make_req(REQ_READ, 3, 0, 0, 0, 0, 1'b0));
    send_request(make_req(REQ_READ, 4, 0, 0, 0, 0, 1'b0));
    settle();

    // Random part over several walk counts, zero and one among them
    write_count(CNT_W'(0));
    run_random_phase(28);
    settle();
    write_count(CNT_W'(1));
    run_random_phase(14);
    // hold the sender until every expected word has come back, then resume
    settle();
    run_random_phase(14);
    settle();
    write_count(CNT_W'($urandom_range(2, 15)));
    run_random_phase(28);
    settle();
    write_count(CNT_W'(16));
    run_random_phase(20);
    settle();

    // Last part, no idling: back-to-back words over the sixteen walked vertices
    idle_on = 1'b0;
    run_random_phase(12);
    send_request(make_req(REQ_READ, 4095, 0, 0, 0, 0, 1'b0));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 0, 1'b0));
    settle();

    if (tracker.fail_count == 0) begin
      $display("** spherical_fault_terrain_step: PASSED **");
    end else begin
      $display("** spherical_fault_terrain_step: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake; the slowest correct run needs well under a tenth of this
  initial begin
    #5_000_000;
    $display("** spherical_fault_terrain_step: FAILED **");
    $finish;
  end

endmodule
